// ===== src/c6502_pkg.sv =====
// Package for the 6502 subset core: opcodes, command codes, controller
// states and the controller-to-datapath command struct. No dependencies.
package c6502_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_EXEC  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
   localparam logic [15:0] SP_RESET     = 16'h01FF;

   localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLD = 8'hD8, OP_SED = 8'hF8;
   localparam logic [7:0] OP_ADC = 8'h65, OP_LDAZ = 8'hA5, OP_LDXZ = 8'hA6, OP_LDYZ = 8'hA4;
   localparam logic [7:0] OP_LDXI = 8'hA2, OP_LDYI = 8'hA0, OP_STAZ = 8'h85, OP_STXZ = 8'h86;
   localparam logic [7:0] OP_STXA = 8'h8E, OP_STYA = 8'h8C, OP_INX = 8'hE8, OP_INY = 8'hC8;
   localparam logic [7:0] OP_INC = 8'hEE, OP_DEX = 8'hCA, OP_DEY = 8'h88, OP_BNE = 8'hD0;
   localparam logic [7:0] OP_BEQ = 8'hF0, OP_JSR = 8'h20, OP_RTS = 8'h60, OP_JMP = 8'h4C;
   localparam logic [7:0] OP_AND = 8'h29, OP_NOP = 8'hEA;

   // Address source for the single memory port.
   typedef enum logic [2:0] {
      AS_REQ  = 3'd0,  // request address
      AS_PC   = 3'd1,  // PC + offset
      AS_ZP   = 3'd2,  // zero page operand byte
      AS_ABS  = 3'd3,  // absolute operand word
      AS_SP   = 3'd4,  // stack word base + offset
      AS_VEC  = 3'd5,  // reset vector + offset
      AS_PC2  = 3'd6   // PC + 2
   } addr_sel_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_VEC0  = 10'b0000000010,
      ST_VEC1  = 10'b0000000100,
      ST_OP    = 10'b0000001000,
      ST_B1    = 10'b0000010000,
      ST_B2    = 10'b0000100000,
      ST_DATA  = 10'b0001000000,
      ST_WR0   = 10'b0010000000,
      ST_WR1   = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   // Command from controller to datapath.
   typedef struct packed {
      addr_sel_type sel;
      logic         off;       // add one to the base address
      logic         mem_rd;    // issue a read; data is valid next cycle
      logic         mem_wr;
      logic         load_cmd;  // latch the request beat
      logic         cap_vec0;
      logic         cap_vec1;
      logic         cap_op;
      logic         cap_b1;
      logic         cap_b2;
      logic         cap_data;
      logic         cap_read;  // capture the read-command byte
      logic         wr_hi;     // JSR high byte
      logic         exec;      // commit the instruction
      logic         do_reset;  // commit the core reset
      logic         clear_rb;
   } ctl_type;

   typedef struct packed {
      logic [7:0] opcode;
   } stat_type;

endpackage

// ===== src/cpu6502_subset_core.sv =====
// Top level of the 6502 subset core: joins the controller and the datapath.
// Depends on c6502_pkg, c6502_control and c6502_datapath.
//
// One command is taken at a time: start is accepted when busy is low, and
// the result beat appears on the rsp_ ports with rsp_valid high for exactly
// one cycle, which the receiver cannot stall. How long a command runs is set
// by the one memory port that every byte access shares, so an execute takes
// longer for opcodes that fetch or move more bytes.
// The memory is not cleared by reset; bytes must be written before use.
module cpu6502_subset_core #(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_accum,
   output logic [7:0]  rsp_index_x,
   output logic [7:0]  rsp_index_y,
   output logic [15:0] rsp_stack_ptr,
   output logic        rsp_carry,
   output logic        rsp_zero_flag,
   output logic        rsp_decimal_mode,
   output logic        rsp_negative,
   output logic        rsp_illegal,
   output logic [7:0]  rsp_read_byte
);

   c6502_pkg::ctl_type  ctl;
   c6502_pkg::stat_type stat;
   logic [3:0] flags;

   c6502_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .req_command(req_command),
      .stat(stat), .ctl(ctl), .busy(busy), .done(rsp_valid)
   );

   c6502_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat),
      .req_command(req_command), .req_address(req_address), .req_data(req_data),
      .pc_q(rsp_prog_counter), .a_q(rsp_accum), .x_q(rsp_index_x),
      .y_q(rsp_index_y), .sp_q(rsp_stack_ptr), .flags_q(flags),
      .illegal_q(rsp_illegal), .read_byte_q(rsp_read_byte)
   );

   assign rsp_carry = flags[3];
   assign rsp_zero_flag = flags[2];
   assign rsp_decimal_mode = flags[1];
   assign rsp_negative = flags[0];

endmodule

// ===== src/c6502_datapath.sv =====
// Datapath of the 6502 subset core: memory, register file and execute logic.
// Depends on c6502_pkg.
module c6502_datapath #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  c6502_pkg::ctl_type   ctl,
   output c6502_pkg::stat_type  stat,
   input  logic [1:0]           req_command,
   input  logic [15:0]          req_address,
   input  logic [7:0]           req_data,
   output logic [15:0]          pc_q,
   output logic [7:0]           a_q,
   output logic [7:0]           x_q,
   output logic [7:0]           y_q,
   output logic [15:0]          sp_q,
   output logic [3:0]           flags_q,   // C Z D N from high to low
   output logic                 illegal_q,
   output logic [7:0]           read_byte_q
);

   logic [7:0] mem [0:(1 << ADDR_BITS) - 1];
   logic [7:0] rdata_ff;
   logic [15:0] addr_ff;
   logic [1:0] cmd_ff;
   logic [7:0] data_ff;
   logic [7:0] op_ff, b1_ff, b2_ff, dat_ff, v0_ff;
   logic [15:0] pc_ff, pc_in, sp_ff, sp_in;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, rb_ff;
   logic c_ff, c_in, z_ff, z_in, d_ff, d_in, n_ff, n_in, ill_ff, ill_in;
   logic [15:0] base, maddr;
   logic [7:0] wdata;
   logic [8:0] sum;
   logic [7:0] res;
   logic set_zn;
   logic [15:0] next2, w1;

   assign w1 = {b2_ff, b1_ff};

   always_comb begin
      case (ctl.sel)
         c6502_pkg::AS_REQ: base = addr_ff;
         c6502_pkg::AS_PC:  base = pc_ff;
         c6502_pkg::AS_ZP:  base = {8'd0, b1_ff};
         c6502_pkg::AS_ABS: base = w1;
         // JSR pushes below the current SP; RTS pops from SP itself.
         c6502_pkg::AS_SP:  base = (op_ff == c6502_pkg::OP_JSR) ? sp_ff - 16'd2 : sp_ff;
         c6502_pkg::AS_VEC: base = c6502_pkg::RESET_VECTOR;
         c6502_pkg::AS_PC2: base = pc_ff + 16'd2;
         default:           base = addr_ff;
      endcase
      maddr = base + {15'd0, ctl.off};
   end

   // Store data: JSR pushes PC + 2, others store a register or the INC result.
   always_comb begin
      next2 = pc_ff + 16'd2;
      if (cmd_ff == c6502_pkg::CMD_WRITE) begin
         wdata = data_ff;
      end else begin
         case (op_ff)
            c6502_pkg::OP_STAZ: wdata = a_ff;
            c6502_pkg::OP_STXZ, c6502_pkg::OP_STXA: wdata = x_ff;
            c6502_pkg::OP_STYA: wdata = y_ff;
            c6502_pkg::OP_INC:  wdata = dat_ff + 8'd1;
            c6502_pkg::OP_JSR:  wdata = ctl.wr_hi ? next2[15:8] : next2[7:0];
            default:            wdata = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[maddr[ADDR_BITS-1:0]] <= wdata;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= mem[maddr[ADDR_BITS-1:0]];
      end
      if (ctl.load_cmd) begin
         addr_ff  <= req_address;
         data_ff  <= req_data;
         cmd_ff   <= req_command;
      end
      if (ctl.cap_vec0) v0_ff <= rdata_ff;
      if (ctl.cap_op)   op_ff <= rdata_ff;
      if (ctl.cap_b1)   b1_ff <= rdata_ff;
      if (ctl.cap_b2)   b2_ff <= rdata_ff;
      if (ctl.cap_data) dat_ff <= rdata_ff;
   end

   assign stat.opcode = op_ff;

   always_comb begin
      pc_in = pc_ff; sp_in = sp_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff;
      c_in = c_ff; z_in = z_ff; d_in = d_ff; n_in = n_ff; ill_in = ill_ff;
      sum = {1'b0, a_ff} + {1'b0, dat_ff} + {8'd0, c_ff};
      res = 8'd0;
      set_zn = 1'b0;
      if (ctl.do_reset) begin
         a_in = 8'd0; x_in = 8'd0; y_in = 8'd0;
         c_in = 1'b0; z_in = 1'b0; d_in = 1'b0; n_in = 1'b0;
         sp_in = c6502_pkg::SP_RESET;
         pc_in = {rdata_ff, v0_ff};
         ill_in = 1'b0;
      end else if (ctl.exec) begin
         ill_in = 1'b0;
         case (op_ff)
            c6502_pkg::OP_CLC: begin c_in = 1'b0; pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_SEC: begin c_in = 1'b1; pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_CLD: begin d_in = 1'b0; pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_SED: begin d_in = 1'b1; pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_ADC: begin
               c_in = sum[8]; res = sum[7:0]; a_in = res; set_zn = 1'b1;
               pc_in = next2;
            end
            c6502_pkg::OP_LDAZ: begin res = dat_ff; a_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_LDXZ: begin res = dat_ff; x_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_LDYZ: begin res = dat_ff; y_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_LDXI: begin res = b1_ff; x_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_LDYI: begin res = b1_ff; y_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_AND: begin res = a_ff & b1_ff; a_in = res; set_zn = 1'b1;
               pc_in = next2; end
            c6502_pkg::OP_STAZ, c6502_pkg::OP_STXZ: pc_in = next2;
            c6502_pkg::OP_STXA, c6502_pkg::OP_STYA: pc_in = pc_ff + 16'd3;
            c6502_pkg::OP_INX: begin res = x_ff + 8'd1; x_in = res; set_zn = 1'b1;
               pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_INY: begin res = y_ff + 8'd1; y_in = res; set_zn = 1'b1;
               pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_DEX: begin res = x_ff - 8'd1; x_in = res; set_zn = 1'b1;
               pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_DEY: begin res = y_ff - 8'd1; y_in = res; set_zn = 1'b1;
               pc_in = pc_ff + 16'd1; end
            c6502_pkg::OP_INC: begin res = dat_ff + 8'd1; set_zn = 1'b1;
               pc_in = pc_ff + 16'd3; end
            c6502_pkg::OP_BNE: pc_in = !z_ff ? next2 + {{8{b1_ff[7]}}, b1_ff} : next2;
            c6502_pkg::OP_BEQ: pc_in = z_ff ? next2 + {{8{b1_ff[7]}}, b1_ff} : next2;
            c6502_pkg::OP_JSR: begin sp_in = sp_ff - 16'd2; pc_in = w1; end
            c6502_pkg::OP_RTS: begin
               // RTS reads the low byte into dat_ff and the high byte last.
               pc_in = {rdata_ff, dat_ff} + 16'd1;
               sp_in = sp_ff + 16'd2;
            end
            c6502_pkg::OP_JMP: pc_in = w1;
            c6502_pkg::OP_NOP: pc_in = pc_ff + 16'd1;
            default: ill_in = 1'b1;
         endcase
         if (set_zn) begin
            z_in = (res == 8'd0);
            n_in = res[7];
         end
      end else if (ctl.load_cmd) begin
         ill_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 16'd0; sp_ff <= c6502_pkg::SP_RESET;
         a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         c_ff <= 1'b0; z_ff <= 1'b0; d_ff <= 1'b0; n_ff <= 1'b0;
         ill_ff <= 1'b0; rb_ff <= 8'd0;
      end else begin
         pc_ff <= pc_in; sp_ff <= sp_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         c_ff <= c_in; z_ff <= z_in; d_ff <= d_in; n_ff <= n_in;
         ill_ff <= ill_in;
         if (ctl.clear_rb) rb_ff <= 8'd0;
         else if (ctl.cap_read) rb_ff <= rdata_ff;
      end
   end

   assign pc_q = pc_ff;
   assign a_q = a_ff;
   assign x_q = x_ff;
   assign y_q = y_ff;
   assign sp_q = sp_ff;
   assign flags_q = {c_ff, z_ff, d_ff, n_ff};
   assign illegal_q = ill_ff;
   assign read_byte_q = rb_ff;

endmodule

// ===== src/c6502_control.sv =====
// Controller state machine of the 6502 subset core: sequences the memory
// accesses of each command. Depends on c6502_pkg.
module c6502_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_command,
   input  c6502_pkg::stat_type  stat,
   output c6502_pkg::ctl_type   ctl,
   output logic                 busy,
   output logic                 done
);

   c6502_pkg::state_type state_ff, state_in;
   logic [1:0] cmd_ff;
   logic [7:0] op;
   logic three_byte, zp_read, abs_read, is_store_zp, is_store_abs;
   logic is_jsr, is_rts;

   assign op = stat.opcode;

   always_comb begin
      three_byte = 1'b0; zp_read = 1'b0; abs_read = 1'b0;
      is_store_zp = 1'b0; is_store_abs = 1'b0;
      is_jsr = (op == c6502_pkg::OP_JSR);
      is_rts = (op == c6502_pkg::OP_RTS);
      case (op)
         c6502_pkg::OP_ADC, c6502_pkg::OP_LDAZ, c6502_pkg::OP_LDXZ,
         c6502_pkg::OP_LDYZ: zp_read = 1'b1;
         c6502_pkg::OP_STAZ, c6502_pkg::OP_STXZ: is_store_zp = 1'b1;
         c6502_pkg::OP_STXA, c6502_pkg::OP_STYA: begin
            three_byte = 1'b1; is_store_abs = 1'b1; end
         c6502_pkg::OP_INC: begin three_byte = 1'b1; abs_read = 1'b1; end
         c6502_pkg::OP_JSR, c6502_pkg::OP_JMP: three_byte = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.sel = c6502_pkg::AS_REQ;
      state_in = state_ff;
      done = 1'b0;
      case (state_ff)
         c6502_pkg::ST_IDLE: begin
            if (start) begin
               ctl.load_cmd = 1'b1;
               ctl.clear_rb = 1'b1;
               case (req_command)
                  c6502_pkg::CMD_WRITE: state_in = c6502_pkg::ST_WR0;
                  c6502_pkg::CMD_READ:  state_in = c6502_pkg::ST_B1;
                  c6502_pkg::CMD_RESET: begin
                     ctl.sel = c6502_pkg::AS_VEC; ctl.mem_rd = 1'b1;
                     state_in = c6502_pkg::ST_VEC0;
                  end
                  default: begin
                     ctl.sel = c6502_pkg::AS_PC; ctl.mem_rd = 1'b1;
                     state_in = c6502_pkg::ST_OP;
                  end
               endcase
            end
         end
         c6502_pkg::ST_VEC0: begin
            ctl.cap_vec0 = 1'b1;
            ctl.sel = c6502_pkg::AS_VEC; ctl.off = 1'b1; ctl.mem_rd = 1'b1;
            state_in = c6502_pkg::ST_VEC1;
         end
         c6502_pkg::ST_VEC1: begin
            ctl.do_reset = 1'b1;
            state_in = c6502_pkg::ST_DONE;
         end
         c6502_pkg::ST_OP: begin
            // Opcode arrives; fetch the first operand byte.
            ctl.cap_op = 1'b1;
            ctl.sel = c6502_pkg::AS_PC; ctl.off = 1'b1; ctl.mem_rd = 1'b1;
            state_in = c6502_pkg::ST_B1;
         end
         c6502_pkg::ST_B1: begin
            if (cmd_ff == c6502_pkg::CMD_READ) begin
               // Read command: issue the read here, data captured in ST_WR1.
               ctl.sel = c6502_pkg::AS_REQ; ctl.mem_rd = 1'b1;
               state_in = c6502_pkg::ST_WR1;
            end else begin
               ctl.cap_b1 = 1'b1;
               if (is_rts) begin
                  ctl.sel = c6502_pkg::AS_SP; ctl.mem_rd = 1'b1;
                  state_in = c6502_pkg::ST_DATA;
               end else if (three_byte) begin
                  ctl.sel = c6502_pkg::AS_PC2; ctl.mem_rd = 1'b1;
                  state_in = c6502_pkg::ST_B2;
               end else if (zp_read) begin
                  // b1 not yet in its register: state B2 reissues via zp.
                  state_in = c6502_pkg::ST_B2;
               end else if (is_store_zp) begin
                  state_in = c6502_pkg::ST_WR0;
               end else begin
                  state_in = c6502_pkg::ST_WR1;
               end
            end
         end
         c6502_pkg::ST_B2: begin
            if (zp_read) begin
               ctl.sel = c6502_pkg::AS_ZP; ctl.mem_rd = 1'b1;
               state_in = c6502_pkg::ST_DATA;
            end else begin
               ctl.cap_b2 = 1'b1;
               if (abs_read) state_in = c6502_pkg::ST_DATA;
               else if (is_store_abs || is_jsr) state_in = c6502_pkg::ST_WR0;
               else state_in = c6502_pkg::ST_WR1;
            end
         end
         c6502_pkg::ST_DATA: begin
            if (abs_read) begin
               // The absolute read is issued here and captured in ST_WR0.
               ctl.sel = c6502_pkg::AS_ABS; ctl.mem_rd = 1'b1;
               state_in = c6502_pkg::ST_WR0;
            end else if (is_rts) begin
               ctl.cap_data = 1'b1;
               ctl.sel = c6502_pkg::AS_SP; ctl.off = 1'b1; ctl.mem_rd = 1'b1;
               state_in = c6502_pkg::ST_WR1;
            end else begin
               ctl.cap_data = 1'b1;
               state_in = c6502_pkg::ST_WR1;
            end
         end
         c6502_pkg::ST_WR0: begin
            if (cmd_ff == c6502_pkg::CMD_WRITE) begin
               ctl.mem_wr = 1'b1;
               state_in = c6502_pkg::ST_DONE;
            end else if (abs_read) begin
               ctl.cap_data = 1'b1;
               state_in = c6502_pkg::ST_WR1;
            end else if (is_jsr) begin
               ctl.sel = c6502_pkg::AS_SP; ctl.mem_wr = 1'b1;
               state_in = c6502_pkg::ST_WR1;
            end else begin
               ctl.sel = is_store_zp ? c6502_pkg::AS_ZP : c6502_pkg::AS_ABS;
               ctl.mem_wr = 1'b1;
               ctl.exec = 1'b1;
               state_in = c6502_pkg::ST_DONE;
            end
         end
         c6502_pkg::ST_WR1: begin
            if (cmd_ff == c6502_pkg::CMD_READ) begin
               ctl.cap_read = 1'b1;
            end else if (abs_read) begin
               ctl.sel = c6502_pkg::AS_ABS; ctl.mem_wr = 1'b1;
               ctl.exec = 1'b1;
            end else if (is_jsr) begin
               ctl.sel = c6502_pkg::AS_SP; ctl.off = 1'b1; ctl.wr_hi = 1'b1;
               ctl.mem_wr = 1'b1;
               ctl.exec = 1'b1;
            end else begin
               ctl.exec = 1'b1;
            end
            state_in = c6502_pkg::ST_DONE;
         end
         c6502_pkg::ST_DONE: begin
            done = 1'b1;
            state_in = c6502_pkg::ST_IDLE;
         end
         default: state_in = c6502_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c6502_pkg::ST_IDLE;
         cmd_ff <= c6502_pkg::CMD_WRITE;
      end else begin
         state_ff <= state_in;
         if (ctl.load_cmd) cmd_ff <= req_command;
      end
   end

   assign busy = (state_ff != c6502_pkg::ST_IDLE);

endmodule

// ===== src/c6502_checker.sv =====
// Port-level checker for the 6502 subset core, bound to the top level.
// Depends only on the top level's ports.
module c6502_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_stack_ptr,
   input logic [7:0]  rsp_read_byte
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start beat not taken");

   a_valid_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat held");

   a_idle_after_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("core busy after result beat");

   a_no_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   a_sp_stable_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) && !$past(reset) |-> $stable(rsp_stack_ptr)
      && $stable(rsp_read_byte)) else $error("state moved while idle");

endmodule

bind cpu6502_subset_core c6502_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_stack_ptr(rsp_stack_ptr),
   .rsp_read_byte(rsp_read_byte)
);

// ===== test/cpu6502_subset_core_tb.sv =====
// Testbench for cpu6502_subset_core: drives write, read, core reset and execute
// commands and checks every result beat against an in-bench model of the core.
// Depends on c6502_pkg and the RTL of the core.
module cpu6502_subset_core_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] sp;
      logic        c;
      logic        z;
      logic        d;
      logic        n;
      logic        ill;
      logic [7:0]  rb;
   } core_view_type;

   class cpu_scoreboard;
      logic [7:0] mem [65536];
      bit written [65536];
      logic [15:0] known_addrs[$];
      logic [15:0] pc, sp;
      logic [7:0] a, x, y;
      bit c, z, d, n;
      core_view_type due[$];
      int errors;

      function new();
         pc = 16'h0000;
         sp = c6502_pkg::SP_RESET;
         a = 8'h00;
         x = 8'h00;
         y = 8'h00;
         c = 0;
         z = 0;
         d = 0;
         n = 0;
         errors = 0;
      endfunction

      function void store(logic [15:0] ad, logic [7:0] v);
         mem[ad] = v;
         if (!written[ad]) begin
            written[ad] = 1;
            known_addrs.push_back(ad);
         end
      endfunction

      function void set_zn(logic [7:0] v);
         z = (v == 8'h00);
         n = v[7];
      endfunction

      // Runs the instruction at PC; returns 0 for an unsupported opcode.
      function bit run_insn();
         logic [7:0] op, b1, v;
         logic [15:0] w1, p1, p2, len;
         logic [8:0] sum;
         p1 = pc + 16'd1;
         p2 = pc + 16'd2;
         op = mem[pc];
         b1 = mem[p1];
         w1 = {mem[p2], b1};
         len = 16'd1;
         case (op)
            c6502_pkg::OP_CLC: c = 0;
            c6502_pkg::OP_SEC: c = 1;
            c6502_pkg::OP_CLD: d = 0;
            c6502_pkg::OP_SED: d = 1;
            c6502_pkg::OP_ADC: begin
               sum = {1'b0, a} + {1'b0, mem[{8'h00, b1}]} + {8'h00, c};
               c = sum[8];
               a = sum[7:0];
               set_zn(a);
               len = 16'd2;
            end
            c6502_pkg::OP_LDAZ: begin a = mem[{8'h00, b1}]; set_zn(a); len = 16'd2; end
            c6502_pkg::OP_LDXZ: begin x = mem[{8'h00, b1}]; set_zn(x); len = 16'd2; end
            c6502_pkg::OP_LDYZ: begin y = mem[{8'h00, b1}]; set_zn(y); len = 16'd2; end
            c6502_pkg::OP_LDXI: begin x = b1; set_zn(x); len = 16'd2; end
            c6502_pkg::OP_LDYI: begin y = b1; set_zn(y); len = 16'd2; end
            c6502_pkg::OP_STAZ: begin store({8'h00, b1}, a); len = 16'd2; end
            c6502_pkg::OP_STXZ: begin store({8'h00, b1}, x); len = 16'd2; end
            c6502_pkg::OP_STXA: begin store(w1, x); len = 16'd3; end
            c6502_pkg::OP_STYA: begin store(w1, y); len = 16'd3; end
            c6502_pkg::OP_INX: begin x = x + 8'd1; set_zn(x); end
            c6502_pkg::OP_INY: begin y = y + 8'd1; set_zn(y); end
            c6502_pkg::OP_DEX: begin x = x - 8'd1; set_zn(x); end
            c6502_pkg::OP_DEY: begin y = y - 8'd1; set_zn(y); end
            c6502_pkg::OP_INC: begin
               v = mem[w1] + 8'd1;
               store(w1, v);
               set_zn(v);
               len = 16'd3;
            end
            c6502_pkg::OP_BNE: begin
               pc = !z ? p2 + {{8{b1[7]}}, b1} : p2;
               return 1;
            end
            c6502_pkg::OP_BEQ: begin
               pc = z ? p2 + {{8{b1[7]}}, b1} : p2;
               return 1;
            end
            c6502_pkg::OP_JSR: begin
               sp = sp - 16'd2;
               store(sp, p2[7:0]);
               store(sp + 16'd1, p2[15:8]);
               pc = w1;
               return 1;
            end
            c6502_pkg::OP_RTS: begin
               pc = {mem[sp + 16'd1], mem[sp]} + 16'd1;
               sp = sp + 16'd2;
               return 1;
            end
            c6502_pkg::OP_JMP: begin pc = w1; return 1; end
            c6502_pkg::OP_AND: begin a = a & b1; set_zn(a); len = 16'd2; end
            c6502_pkg::OP_NOP: ;
            default: return 0;
         endcase
         pc = pc + len;
         return 1;
      endfunction

      function void note_command(logic [1:0] cmd, logic [15:0] ad, logic [7:0] dat);
         core_view_type e;
         bit ill;
         logic [7:0] rb;
         ill = 0;
         rb = 8'h00;
         case (cmd)
            c6502_pkg::CMD_WRITE: store(ad, dat);
            c6502_pkg::CMD_RESET: begin
               a = 8'h00;
               x = 8'h00;
               y = 8'h00;
               c = 0;
               z = 0;
               d = 0;
               n = 0;
               pc = {mem[c6502_pkg::RESET_VECTOR + 16'd1], mem[c6502_pkg::RESET_VECTOR]};
               sp = c6502_pkg::SP_RESET;
            end
            c6502_pkg::CMD_EXEC: ill = !run_insn();
            default: rb = mem[ad];
         endcase
         e = '{pc, a, x, y, sp, c, z, d, n, ill, rb};
         due.push_back(e);
      endfunction

      function void compare(string field, logic [15:0] exp_v, logic [15:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", field, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(core_view_type act);
         core_view_type e;
         if (due.size() == 0) begin
            $error("result beat with no command outstanding");
            errors++;
            return;
         end
         e = due.pop_front();
         compare("prog_counter", e.pc, act.pc);
         compare("accum", 16'(e.a), 16'(act.a));
         compare("index_x", 16'(e.x), 16'(act.x));
         compare("index_y", 16'(e.y), 16'(act.y));
         compare("stack_ptr", e.sp, act.sp);
         compare("carry", 16'(e.c), 16'(act.c));
         compare("zero_flag", 16'(e.z), 16'(act.z));
         compare("decimal_mode", 16'(e.d), 16'(act.d));
         compare("negative", 16'(e.n), 16'(act.n));
         compare("illegal", 16'(e.ill), 16'(act.ill));
         compare("read_byte", 16'(e.rb), 16'(act.rb));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_command = c6502_pkg::CMD_WRITE;
   logic [15:0] req_address = 16'h0000;
   logic [7:0]  req_data = 8'h00;
   logic        rsp_valid;
   logic [15:0] rsp_prog_counter, rsp_stack_ptr;
   logic [7:0]  rsp_accum, rsp_index_x, rsp_index_y, rsp_read_byte;
   logic        rsp_carry, rsp_zero_flag, rsp_decimal_mode, rsp_negative, rsp_illegal;

   cpu_scoreboard sb = new();
   int cycles = 0;
   int sent = 0;
   logic [7:0] op_list [26] = '{
      c6502_pkg::OP_CLC, c6502_pkg::OP_SEC, c6502_pkg::OP_CLD, c6502_pkg::OP_SED,
      c6502_pkg::OP_ADC, c6502_pkg::OP_LDAZ, c6502_pkg::OP_LDXZ, c6502_pkg::OP_LDYZ,
      c6502_pkg::OP_LDXI, c6502_pkg::OP_LDYI, c6502_pkg::OP_STAZ, c6502_pkg::OP_STXZ,
      c6502_pkg::OP_STXA, c6502_pkg::OP_STYA, c6502_pkg::OP_INX, c6502_pkg::OP_INY,
      c6502_pkg::OP_INC, c6502_pkg::OP_DEX, c6502_pkg::OP_DEY, c6502_pkg::OP_BNE,
      c6502_pkg::OP_BEQ, c6502_pkg::OP_JSR, c6502_pkg::OP_RTS, c6502_pkg::OP_JMP,
      c6502_pkg::OP_AND, c6502_pkg::OP_NOP};

   cpu6502_subset_core u_dut (
      .clock, .reset, .start, .busy, .req_command, .req_address, .req_data,
      .rsp_valid, .rsp_prog_counter, .rsp_accum, .rsp_index_x, .rsp_index_y,
      .rsp_stack_ptr, .rsp_carry, .rsp_zero_flag, .rsp_decimal_mode, .rsp_negative,
      .rsp_illegal, .rsp_read_byte
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cpu6502_subset_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_prog_counter, rsp_accum, rsp_index_x, rsp_index_y,
            rsp_stack_ptr, rsp_carry, rsp_zero_flag, rsp_decimal_mode, rsp_negative,
            rsp_illegal, rsp_read_byte});
   end

   // Presents one command beat; start stays high after acceptance so that a
   // zero gap runs back to back. Returns at the falling edge after acceptance.
   task automatic send(logic [1:0] cmd, logic [15:0] ad, logic [7:0] dat);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_command <= cmd;
      req_address <= ad;
      req_data <= dat;
      do @(posedge clock); while (busy);
      sb.note_command(cmd, ad, dat);
      sent++;
      @(negedge clock);
   endtask

   task automatic fill_byte(logic [15:0] ad);
      if (!sb.written[ad])
         send(c6502_pkg::CMD_WRITE, ad, 8'($urandom));
   endtask

   // Writes the opcode if asked or if PC holds no byte yet, and any byte the instruction will read, then executes.
   task automatic run_exec(logic [7:0] op, bit put_op);
      logic [15:0] p, p1, p2, w1;
      logic [7:0] cur;
      p = sb.pc;
      p1 = p + 16'd1;
      p2 = p + 16'd2;
      if (put_op || !sb.written[p])
         send(c6502_pkg::CMD_WRITE, p, op);
      fill_byte(p1);
      fill_byte(p2);
      cur = sb.mem[p];
      w1 = {sb.mem[p2], sb.mem[p1]};
      case (cur)
         c6502_pkg::OP_ADC, c6502_pkg::OP_LDAZ, c6502_pkg::OP_LDXZ,
         c6502_pkg::OP_LDYZ: fill_byte({8'h00, sb.mem[p1]});
         c6502_pkg::OP_INC: fill_byte(w1);
         c6502_pkg::OP_RTS: begin
            fill_byte(sb.sp);
            fill_byte(sb.sp + 16'd1);
         end
         default: ;
      endcase
      send(c6502_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
   endtask

   task automatic core_reset(bit new_vector);
      if (new_vector || !sb.written[c6502_pkg::RESET_VECTOR])
         send(c6502_pkg::CMD_WRITE, c6502_pkg::RESET_VECTOR, 8'($urandom));
      if (new_vector || !sb.written[c6502_pkg::RESET_VECTOR + 16'd1])
         send(c6502_pkg::CMD_WRITE, c6502_pkg::RESET_VECTOR + 16'd1, 8'($urandom));
      send(c6502_pkg::CMD_RESET, 16'($urandom), 8'($urandom));
   endtask

   // Drops start so that the last beat is not taken again, then waits for
   // every outstanding result.
   task automatic wait_drained();
      start <= 0;
      while (sb.due.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_opcode();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom);
      return op_list[$urandom_range(0, 25)];
   endfunction

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes, a vector near the top of memory so that
      // operand fetches wrap, and a few flag and branch corner cases.
      send(c6502_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
      send(c6502_pkg::CMD_WRITE, 16'h0000, 8'h00);
      send(c6502_pkg::CMD_READ, 16'hFFFF, 8'h00);
      send(c6502_pkg::CMD_READ, 16'h0000, 8'hFF);
      send(c6502_pkg::CMD_WRITE, c6502_pkg::RESET_VECTOR, 8'hFE);
      send(c6502_pkg::CMD_WRITE, c6502_pkg::RESET_VECTOR + 16'd1, 8'hFF);
      core_reset(0);
      run_exec(c6502_pkg::OP_LDXI, 1);
      run_exec(c6502_pkg::OP_INX, 1);
      run_exec(c6502_pkg::OP_BEQ, 1);
      run_exec(8'h02, 1);
      run_exec(c6502_pkg::OP_SEC, 1);
      run_exec(c6502_pkg::OP_SED, 1);
      wait_drained();

      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            run_exec(pick_opcode(), $urandom_range(0, 2) == 0);
         else if (pick < 80)
            send(c6502_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
         else if (pick < 94)
            send(c6502_pkg::CMD_READ,
                 sb.known_addrs[$urandom_range(0, sb.known_addrs.size() - 1)],
                 8'($urandom));
         else
            core_reset(1'($urandom_range(0, 1)));
         if ($urandom_range(0, 149) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("cpu6502_subset_core: match");
      else
         $display("cpu6502_subset_core: mismatch");
      $finish;
   end
endmodule
